// ===== rtl/mtc_pkg.sv =====
// Shared constants, field widths and MFM helpers for the MFM track codec.
`timescale 1ns / 1ps

package mtc_pkg;

    // Field widths
    localparam int POS_W  = 17;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 18;

    // Stream payload widths (tdata fields padded to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // Track geometry
    localparam int TRACK_BITS_DEF = 131072;
    localparam int MIN_LEN        = 16;
    localparam int CELLS_PER_BYTE = 16;

    localparam logic [LEN_W-1:0] LEN_RST = 18'd131072;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Bit masks for the first data bit and the last one
    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LSB_MASK = 8'h01;

    // Encode one cell: the clock cell (first of a pair) is set only between two zeros,
    // the data cell (second of a pair) carries the data bit
    function automatic logic mfm_cell(input logic bit_val, input logic last_val,
                                      input logic second);
        logic cell_val;
        if (second) begin
            cell_val = bit_val;
        end else begin
            cell_val = ~bit_val & ~last_val;
        end
        return cell_val;
    endfunction

    // Decode 16 cells, first cell in bit 15: a data bit is one for a 01 pair
    function automatic logic [BYTE_W-1:0] mfm_decode(input logic [CELLS_PER_BYTE-1:0] cells);
        logic [BYTE_W-1:0] res;
        for (int i = 0; i < BYTE_W; i++) begin
            res[i] = ~cells[2*i+1] & cells[2*i];
        end
        return res;
    endfunction

endpackage

// ===== rtl/mfm_track_codec.sv =====
// MFM track codec: circular cell track, cursor, shared remainder unit and cell sequencer.
`timescale 1ns / 1ps

// One item is taken at a time, a write (encode) item or a read (decode) item;
// the single-port track memory moves one cell per cycle and paces both kinds.
// When the item loads a new position, or the cursor lies at or beyond a shortened
// track length, the position is first reduced modulo the track length by a
// bit-serial shift/subtract unit; a position already below the length skips it.
// After reset the track memory is cleared one cell per cycle, and s_tready
// stays low meanwhile; configuration writes are taken at any time. A finished
// result waits in the output register while the next item is taken.
module mfm_track_codec #(
    parameter int TRACK_BITS = mtc_pkg::TRACK_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: track_length
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtc_pkg::LEN_W-1:0]     cfg_wdata,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mtc_pkg::S_TDATA_W-1:0] s_tdata,  // position[16:0], data_byte[24:17]
    input  logic [mtc_pkg::S_TUSER_W-1:0] s_tuser,  // func[0], start_req[1]
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtc_pkg::M_TDATA_W-1:0] m_tdata   // read_byte[7:0], next_position[24:8]
);

    localparam int AW     = $clog2(TRACK_BITS);
    localparam int NW     = AW + 1;
    localparam int DW     = (AW > mtc_pkg::POS_W) ? AW : mtc_pkg::POS_W;
    localparam int KW     = (DW > NW) ? DW : NW;
    localparam int CW     = (mtc_pkg::LEN_W > NW) ? mtc_pkg::LEN_W : NW;
    localparam int CNT_W  = $clog2(DW + 1);
    localparam int PAD_W  = mtc_pkg::M_TDATA_W - mtc_pkg::POS_W - mtc_pkg::BYTE_W;
    localparam int CELL_W = mtc_pkg::CELLS_PER_BYTE;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PREV,
        ST_LOADL,
        ST_ENC,
        ST_DEC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [mtc_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [AW-1:0]               cursor_reg, cursor_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               div_reg, div_next;
    logic                        func_reg, func_next;
    logic [mtc_pkg::BYTE_W-1:0]  data_reg, data_next;
    logic                        last_reg, last_next;
    logic [CELL_W-1:0]           cells_reg, cells_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [mtc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Track memory, single port, registered read
    logic                        track_mem [TRACK_BITS];
    logic                        rdata_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_addr;
    logic                        mem_wdata;

    logic [CW-1:0]               len_w;
    logic [NW-1:0]               used_len;
    logic [NW-1:0]               cursor_inc;
    logic [AW-1:0]               cursor_adv;
    logic [AW-1:0]               prev_addr;
    logic [DW-1:0]               dividend;
    logic                        in_xfer;
    logic [NW-1:0]               trial;
    logic                        trial_ge;
    logic                        enc_cell;
    logic                        out_free;
    logic [mtc_pkg::BYTE_W-1:0]  out_byte;

    // Track length in use, saturated to the legal range
    always_comb begin
        len_w = CW'(len_reg);
        if (len_w < CW'(mtc_pkg::MIN_LEN)) begin
            used_len = NW'(mtc_pkg::MIN_LEN);
        end else if (len_w > CW'(TRACK_BITS)) begin
            used_len = NW'(TRACK_BITS);
        end else begin
            used_len = NW'(len_w);
        end
    end

    // Cursor step with wrap, and the cell just before the cursor
    assign cursor_inc = NW'(cursor_reg) + NW'(1);
    assign cursor_adv = (cursor_inc >= used_len) ? '0 : AW'(cursor_inc);
    assign prev_addr  = (cursor_reg == '0) ? AW'(used_len - NW'(1)) : cursor_reg - AW'(1);

    // Start value for the cursor of a new item
    assign in_xfer  = s_tvalid & s_tready;
    assign dividend = s_tuser[1] ? DW'(s_tdata[mtc_pkg::POS_W-1:0]) : DW'(cursor_reg);

    // Remainder unit: one restoring subtract step per cycle
    assign trial    = {rem_reg, div_reg[DW-1]};
    assign trial_ge = (trial >= used_len);

    // Encoder cell for the current step
    assign enc_cell = mtc_pkg::mfm_cell(data_reg[mtc_pkg::BYTE_W-1], last_reg, cnt_reg[0]);

    assign out_free = ~m_tvalid_reg | m_tready;
    assign out_byte = (func_reg == mtc_pkg::FUNC_READ) ? mtc_pkg::mfm_decode(cells_reg)
                                                       : '0;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        cursor_next   = cursor_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        func_next     = func_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        cells_next    = cells_reg;
        rd_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_addr      = cursor_reg;
        mem_wdata     = 1'b0;

        if (cfg_valid && cfg_ready) begin
            len_next = cfg_wdata;
        end

        // Result register drains independently of the sequencer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Collect read cells in the cycle after their address
        if (rd_pend_reg) begin
            cells_next = {cells_reg[CELL_W-2:0], rdata_reg};
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (cursor_reg == AW'(TRACK_BITS - 1)) begin
                    cursor_next = '0;
                    state_next  = ST_IDLE;
                end else begin
                    cursor_next = cursor_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    func_next = s_tuser[0];
                    data_next = s_tdata[mtc_pkg::POS_W +: mtc_pkg::BYTE_W];
                    cnt_next  = '0;
                    rem_next  = '0;
                    div_next  = dividend;
                    if (KW'(dividend) >= KW'(used_len)) begin
                        state_next = ST_MOD;
                    end else begin
                        cursor_next = AW'(dividend);
                        state_next  = (s_tuser[0] == mtc_pkg::FUNC_READ) ? ST_DEC : ST_PREV;
                    end
                end
            end
            ST_MOD: begin
                rem_next = trial_ge ? AW'(trial - used_len) : AW'(trial);
                div_next = div_reg << 1;
                if (cnt_reg == CNT_W'(DW - 1)) begin
                    cnt_next    = '0;
                    cursor_next = rem_next;
                    state_next  = (func_reg == mtc_pkg::FUNC_READ) ? ST_DEC : ST_PREV;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PREV: begin
                mem_addr   = prev_addr;
                state_next = ST_LOADL;
            end
            ST_LOADL: begin
                last_next  = rdata_reg;
                state_next = ST_ENC;
            end
            ST_ENC: begin
                mem_we      = 1'b1;
                mem_wdata   = enc_cell;
                cursor_next = cursor_adv;
                // Data cell done: move on to the next data bit
                if (cnt_reg[0]) begin
                    last_next = data_reg[mtc_pkg::BYTE_W-1];
                    data_next = data_reg << 1;
                end
                if (cnt_reg == CNT_W'(CELL_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DEC: begin
                rd_pend_next = 1'b1;
                cursor_next  = cursor_adv;
                if (cnt_reg == CNT_W'(CELL_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), mtc_pkg::POS_W'(cursor_reg), out_byte};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            len_reg      <= mtc_pkg::LEN_RST;
            cursor_reg   <= '0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cursor_reg   <= cursor_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        func_reg    <= func_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
        cells_reg   <= cells_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Track memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            track_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= track_mem[mem_addr];
    end

`ifndef SYNTHESIS
    // One item at a time: no transfer right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Cells are only moved at a cursor inside the track in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENC || state_reg == ST_DEC) |-> (NW'(cursor_reg) < used_len))
        else $error("cursor outside the track length");

    // No input during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input ready during memory clear");

    // A result only appears after a finished item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result without a finished item");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking stream testbench for the MFM track codec: directed table, then random runs.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 1_600_000;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 240;
    localparam int unsigned MAX_POS = 131071;

    // Directed row kinds
    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_CFG  = 1'b1;

    // One result as the block returns it
    typedef struct packed {
        logic [mtc_pkg::BYTE_W-1:0] read_byte;
        logic [mtc_pkg::POS_W-1:0]  next_position;
    } codec_word_t;

    // One directed row: a length write or an item, optionally with a fixed result
    typedef struct packed {
        bit                         kind;
        logic [mtc_pkg::LEN_W-1:0]  len;
        logic                       func;
        logic                       start;
        logic [mtc_pkg::POS_W-1:0]  pos;
        logic [mtc_pkg::BYTE_W-1:0] data;
        bit                         fixed;
        logic [mtc_pkg::BYTE_W-1:0] want_byte;
        logic [mtc_pkg::POS_W-1:0]  want_pos;
    } stim_row_t;

    localparam int NUM_ROWS = 24;

    // Directed part: reset state, track wrap, length extremes, cursor past a shortened track
    stim_row_t steps [NUM_ROWS] = '{
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd0,      8'h00, 1'b1, 8'h00, 17'd16},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd0,      8'hFF, 1'b1, 8'h00, 17'd16},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd0,      8'h00, 1'b1, 8'hFF, 17'd16},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd131071, 8'h00, 1'b1, 8'h00, 17'd15},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd131071, 8'hFF, 1'b1, 8'h00, 17'd15},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b0, 17'h1FFFF,  8'h80, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,      8'h01, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd15,     8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b0, 17'd0,      8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd100,    8'hA5, 1'b0, 8'h00, 17'd0},
        '{ROW_CFG,  18'd16, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,     8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,      8'h5A, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd131071, 8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_CFG,  18'd0, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,      8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd7,      8'hC3, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd7,      8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_CFG, 18'd262143, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,  8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd131071, 8'h3C, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd131071, 8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_CFG,  18'd17, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,     8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_WRITE, 1'b1, 17'd65536,  8'hFF, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b1, 17'd65536,  8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_CFG, 18'd131072, mtc_pkg::FUNC_WRITE, 1'b0, 17'd0,  8'h00, 1'b0, 8'h00, 17'd0},
        '{ROW_ITEM, 18'd0, mtc_pkg::FUNC_READ,  1'b0, 17'd0,      8'h55, 1'b0, 8'h00, 17'd0}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mtc_pkg::LEN_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mtc_pkg::S_TDATA_W-1:0] s_tdata = '0;  // position[16:0], data_byte[24:17]
    logic [mtc_pkg::S_TUSER_W-1:0] s_tuser = '0;  // func[0], start_req[1]
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    logic [mtc_pkg::M_TDATA_W-1:0] m_tdata;       // read_byte[7:0], next_position[24:8]

    // Shadow of the track, cursor and length register
    bit                        track_model [mtc_pkg::TRACK_BITS_DEF];
    logic [mtc_pkg::POS_W-1:0] cursor_model = '0;
    logic [mtc_pkg::LEN_W-1:0] length_reg = mtc_pkg::LEN_RST;

    codec_word_t   predicted_words [$];
    int unsigned   mismatches = 0;
    int unsigned   items_taken = 0;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_left = 0;
    bit            quiet = 1'b0;

    mfm_track_codec i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Cell offset after p, wrapping at n
    function automatic int unsigned next_cell(input int unsigned p, input int unsigned n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    // Encode or decode one byte on the shadow track and return the block's result
    function automatic codec_word_t mfm_track_step(input logic func, input logic start,
                                                   input logic [mtc_pkg::POS_W-1:0] pos,
                                                   input logic [mtc_pkg::BYTE_W-1:0] data);
        codec_word_t                res;
        int unsigned                n;
        int unsigned                p;
        logic                       last;
        logic                       c1;
        logic                       c2;
        logic [mtc_pkg::BYTE_W-1:0] decoded;
        n = 32'(length_reg);
        if (n < mtc_pkg::MIN_LEN) n = mtc_pkg::MIN_LEN;
        if (n > mtc_pkg::TRACK_BITS_DEF) n = mtc_pkg::TRACK_BITS_DEF;
        if (start) cursor_model = mtc_pkg::POS_W'(32'(pos) % n);
        p = 32'(cursor_model) % n;
        decoded = '0;
        if (func == mtc_pkg::FUNC_WRITE) begin
            last = track_model[(p == 0) ? n - 1 : p - 1];
            for (int k = mtc_pkg::BYTE_W - 1; k >= 0; k--) begin
                // clock cell only between two zeros, data cell carries the bit
                track_model[p] = ~data[k] & ~last;
                p = next_cell(p, n);
                track_model[p] = data[k];
                p = next_cell(p, n);
                last = data[k];
            end
        end else begin
            for (int k = mtc_pkg::BYTE_W - 1; k >= 0; k--) begin
                c1 = track_model[p];
                p = next_cell(p, n);
                c2 = track_model[p];
                p = next_cell(p, n);
                decoded[k] = ~c1 & c2;
            end
        end
        cursor_model = p[mtc_pkg::POS_W-1:0];
        res.read_byte = decoded;
        res.next_position = p[mtc_pkg::POS_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, seen);
        end
    endtask

    // Present one item in bursts with random gaps; predict once it is transferred
    task automatic send_item(input logic func, input logic start,
                             input logic [mtc_pkg::POS_W-1:0] pos,
                             input logic [mtc_pkg::BYTE_W-1:0] data, input bit fixed,
                             input codec_word_t fixed_word);
        codec_word_t res;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= {start, func};
        s_tdata <= {7'd0, data, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = mfm_track_step(func, start, pos, data);
        predicted_words.push_back(fixed ? fixed_word : res);
        items_taken++;
    endtask

    task automatic send_random(input logic func, input logic start,
                               input logic [mtc_pkg::POS_W-1:0] pos);
        send_item(func, start, pos, mtc_pkg::BYTE_W'($urandom), 1'b0, '0);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (predicted_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_length(input logic [mtc_pkg::LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        length_reg = value;
    endtask

    // Receiver: random stalls of random length, none in quiet phases
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 24);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        codec_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_words.size() == 0) begin
                flag_mismatch("unexpected result", '0, m_tdata);
            end else begin
                want = predicted_words.pop_front();
                if (want.read_byte !== m_tdata[7:0]) begin
                    flag_mismatch("read_byte", 32'(want.read_byte), 32'(m_tdata[7:0]));
                end
                if (want.next_position !== m_tdata[24:8]) begin
                    flag_mismatch("next_position", 32'(want.next_position),
                                  32'(m_tdata[24:8]));
                end
            end
        end
    end

    // Timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        codec_word_t               fixed_word;
        logic [mtc_pkg::LEN_W-1:0] phase_len;
        logic [mtc_pkg::POS_W-1:0] base;
        int unsigned               run_len;
        int unsigned               target;
        int unsigned               pick;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (steps[i].kind == ROW_CFG) begin
                drain_results();
                write_length(steps[i].len);
            end else begin
                fixed_word.read_byte = steps[i].want_byte;
                fixed_word.next_position = steps[i].want_pos;
                send_item(steps[i].func, steps[i].start, steps[i].pos, steps[i].data,
                          steps[i].fixed, fixed_word);
            end
        end

        // Random phases, one track length each
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: phase_len = 18'd16;
                1: phase_len = 18'd131072;
                2: phase_len = 18'd17;
                3: phase_len = 18'd0;
                4: phase_len = 18'd262143;
                5: phase_len = mtc_pkg::LEN_W'($urandom_range(18, 300));
                6: phase_len = mtc_pkg::LEN_W'($urandom_range(300, 8000));
                default: phase_len = mtc_pkg::LEN_W'($urandom_range(0, 262143));
            endcase
            drain_results();
            write_length(phase_len);
            quiet = (ph == 3);
            target = items_taken + PHASE_ITEMS;
            while (items_taken < target) begin
                pick = $urandom_range(0, 9);
                base = mtc_pkg::POS_W'($urandom_range(0, MAX_POS));
                run_len = $urandom_range(1, 6);
                if (pick < 7) begin
                    // write a run, then read it back from the same start
                    for (int k = 0; k < run_len; k++) begin
                        send_random(mtc_pkg::FUNC_WRITE, k == 0,
                                    (k == 0) ? base : mtc_pkg::POS_W'($urandom));
                    end
                    for (int k = 0; k < run_len; k++) begin
                        send_random(mtc_pkg::FUNC_READ, k == 0,
                                    (k == 0) ? base : mtc_pkg::POS_W'($urandom));
                    end
                end else if (pick < 9) begin
                    send_random(1'($urandom), 1'($urandom), mtc_pkg::POS_W'($urandom));
                end else begin
                    // broken run: read back one cell off the written start
                    for (int k = 0; k < run_len; k++) begin
                        send_random(mtc_pkg::FUNC_WRITE, k == 0, base);
                    end
                    send_random(mtc_pkg::FUNC_READ, 1'b1, base + mtc_pkg::POS_W'(1));
                end
                if ($urandom_range(0, 199) == 0) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (predicted_words.size() != 0) begin
            flag_mismatch("missing results", '0, 32'(predicted_words.size()));
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mtc_pkg.sv
rtl/mfm_track_codec.sv
verif/tb.sv
